@@ rtl/core/gavo_pkg.sv @@
// ----------------------------------------------------------------------------
// gavo_pkg
// Types, field widths and codes shared by the golden-angle view order block.
// ----------------------------------------------------------------------------
package gavo_pkg;

    // Field and register widths
    localparam int VC_W       = 11;
    localparam int ETL_W      = 7;
    localparam int CMD_W      = 1;
    localparam int ECHO_W     = 6;
    localparam int SLOT_W     = 10;
    localparam int VIEW_W     = 10;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    // Datapath widths
    localparam int DIV_W    = 19;               // dividend and quotient
    localparam int DVS_W    = 11;               // divisor and remainder
    localparam int CNT_W    = $clog2(DIV_W + 1);
    localparam int GOLD_W   = 32;
    localparam int KE_W     = 2 * ETL_W;        // k * etl
    localparam int GP_W     = KE_W + GOLD_W;    // k * etl * golden ratio
    localparam int NT_W     = 11;               // train count and rounded quotient
    localparam int STRIDE_W = 12;
    localparam int P1_W     = ECHO_W + STRIDE_W;
    localparam int P2_W     = SLOT_W + ETL_W;

    // Golden ratio as an unsigned 0.32 fraction, halved for odd view counts
    localparam logic [GOLD_W-1:0] GOLD_EVEN = 32'd2654435769;
    localparam logic [GOLD_W-1:0] GOLD_ODD  = 32'd1327217884;

    // Parameter defaults and register reset values
    localparam int MAX_ECHOES_DEF = 64;
    localparam int MAX_VIEWS_DEF  = 1024;
    localparam logic [VC_W-1:0]  VIEW_COUNT_RST = 11'd256;
    localparam logic [ETL_W-1:0] ETL_RST        = 7'd8;

    // Commands
    localparam logic [CMD_W-1:0] CMD_BUILD = 1'b0;
    localparam logic [CMD_W-1:0] CMD_QUERY = 1'b1;

    // Status codes
    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOT_BUILT = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RANGE     = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_VIEW_COUNT        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ECHO_TRAIN_LENGTH = 2'd1;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [ECHO_W-1:0] echo_index;
        logic [SLOT_W-1:0] slot_index;
    } t_in_item;

    typedef struct packed {
        logic [VIEW_W-1:0]   view_number;
        logic [STATUS_W-1:0] status;
    } t_out_item;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
        logic [DVS_W-1:0] remainder;
    } t_div_rsp;

endpackage

@@ rtl/core/golden_angle_view_order_unit.sv @@
// ----------------------------------------------------------------------------
// golden_angle_view_order_unit
// Pseudo golden-angle radial view ordering: builds a per-echo offset table and
// a view stride, then maps (echo, slot) queries to view numbers.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                 Payload
//  in        input      i_in_valid / o_in_stall   i_in_data  (t_in_item)
//  out       output     o_out_valid / i_out_stall o_out_data (t_out_item)
//  cfg       input      i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// A query reads the echo offset, forms the dividend and then waits on the 19-step
// shared divider doing the modulo by the view count before its result is registered.
// A build runs one divide per table entry, then a duplicate scan reading the
// offset memory, the duplicate repair, two more divides and the stride.
// Reset restores 256 views and 8 echoes and marks the table as not built.
// One item is in work at a time; the input stalls until the result is taken.
// ----------------------------------------------------------------------------
module golden_angle_view_order_unit import gavo_pkg::*; #(
    parameter int MAX_ECHOES = MAX_ECHOES_DEF,
    parameter int MAX_VIEWS  = MAX_VIEWS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [VC_W-1:0]  r_view_count;
    logic [ETL_W-1:0] r_echo_train_length;
    logic             cfg_wr;
    t_div_req         div_req;
    t_div_rsp         div_rsp;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr = i_cfg_valid &&
                    ((i_cfg_index == CFG_VIEW_COUNT) || (i_cfg_index == CFG_ECHO_TRAIN_LENGTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_view_count        <= VIEW_COUNT_RST;
            r_echo_train_length <= ETL_RST;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_VIEW_COUNT) begin
                r_view_count <= VC_W'(i_cfg_data);
            end else if (i_cfg_index == CFG_ECHO_TRAIN_LENGTH) begin
                r_echo_train_length <= ETL_W'(i_cfg_data);
            end
        end
    end

    gavo_seq #(
        .MAX_ECHOES (MAX_ECHOES),
        .MAX_VIEWS  (MAX_VIEWS)
    ) u_seq (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_in_data           (i_in_data),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_out_data          (o_out_data),
        .i_view_count        (r_view_count),
        .i_echo_train_length (r_echo_train_length),
        .i_cfg_wr            (cfg_wr),
        .o_div_req           (div_req),
        .i_div_rsp           (div_rsp)
    );

    gavo_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

endmodule

@@ rtl/core/gavo_div.sv @@
// ----------------------------------------------------------------------------
// gavo_div
// Shared restoring divider: one quotient bit per cycle, quotient and remainder.
// ----------------------------------------------------------------------------
module gavo_div import gavo_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0] r_quo;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;

    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;
    logic             ge;
    logic [DVS_W-1:0] n_rem;

    // Shift the next dividend bit into the partial remainder and try a subtract.
    assign trial = {r_rem, r_quo[DIV_W-1]};
    assign diff  = trial - {1'b0, r_dvs};
    assign ge    = trial >= {1'b0, r_dvs};
    assign n_rem = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_W);
                r_quo  <= i_req.dividend;
                r_rem  <= '0;
                r_dvs  <= i_req.divisor;
            end else if (r_busy) begin
                r_quo <= {r_quo[DIV_W-2:0], ge};
                r_rem <= n_rem;
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_quo;
    assign o_rsp.remainder = r_rem;

endmodule

@@ rtl/core/gavo_seq.sv @@
// ----------------------------------------------------------------------------
// gavo_seq
// Sequencer: echo table build, duplicate repair, stride and view queries,
// with the table memories and the result register.
// ----------------------------------------------------------------------------
module gavo_seq import gavo_pkg::*; #(
    parameter int MAX_ECHOES = MAX_ECHOES_DEF,
    parameter int MAX_VIEWS  = MAX_VIEWS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_item         i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_item        o_out_data,
    input  logic [VC_W-1:0]  i_view_count,
    input  logic [ETL_W-1:0] i_echo_train_length,
    input  logic             i_cfg_wr,
    output t_div_req         o_div_req,
    input  t_div_rsp         i_div_rsp
);

    localparam int AW = $clog2(MAX_ECHOES);

    typedef enum logic [4:0] {
        S_IDLE,
        S_GMUL1,
        S_GMUL2,
        S_GWAIT,
        S_SRD,
        S_SCMP,
        S_RRD,
        S_RWR,
        S_NT,
        S_NTWAIT,
        S_QT,
        S_QTWAIT,
        S_STRIDE,
        S_QMUL,
        S_QSUM,
        S_QWAIT
    } t_state;

    t_state                r_state;
    logic                  r_ready;
    logic                  r_out_valid;
    t_out_item             r_out;
    logic                  r_div_start;
    logic [DIV_W-1:0]      r_dividend;
    logic [DVS_W-1:0]      r_divisor;
    logic [AW-1:0]         r_k;
    logic [AW-1:0]         r_m;
    logic [AW-1:0]         r_val;
    logic                  r_seen;
    logic [AW-1:0]         r_ndup;
    logic [AW-1:0]         r_nmis;
    logic [KE_W-1:0]       r_ke;
    logic [NT_W-1:0]       r_ntrains;
    logic [NT_W-1:0]       r_q;
    logic [STRIDE_W-1:0]   r_stride;
    logic [ECHO_W-1:0]     r_echo;
    logic [SLOT_W-1:0]     r_slot;
    logic [P1_W-1:0]       r_p1;
    logic [P2_W-1:0]       r_p2;

    // Table memories
    logic [AW-1:0] mem_order [MAX_ECHOES];
    logic [AW-1:0] mem_dup   [MAX_ECHOES];
    logic [AW-1:0] mem_miss  [MAX_ECHOES];
    logic [AW-1:0] r_order_q;
    logic [AW-1:0] r_dup_q;
    logic [AW-1:0] r_miss_q;

    logic                  in_stall;
    logic                  in_take;
    logic                  cfg_ok;
    logic [AW-1:0]         etl_m1;
    logic                  echo_bad;
    logic                  slot_bad;
    logic [GOLD_W-1:0]     gold;
    logic [GP_W-1:0]       gprod;
    logic [P1_W+1:0]       sprod;
    logic                  eq;
    logic                  order_we;
    logic [AW-1:0]         order_waddr;
    logic [AW-1:0]         order_wdata;
    logic [AW-1:0]         order_raddr;
    logic                  dup_we;
    logic                  miss_we;

    assign in_stall = (r_state != S_IDLE) || r_out_valid;
    assign in_take  = i_in_valid && !in_stall;

    assign cfg_ok = (i_view_count != '0) && (32'(i_view_count) <= 32'(MAX_VIEWS)) &&
                    (i_echo_train_length != '0) &&
                    (32'(i_echo_train_length) <= 32'(MAX_ECHOES));
    assign etl_m1   = AW'(i_echo_train_length - ETL_W'(1));
    assign echo_bad = ETL_W'(i_in_data.echo_index) >= i_echo_train_length;
    assign slot_bad = NT_W'(i_in_data.slot_index) >= r_ntrains;

    assign gold  = i_view_count[0] ? GOLD_ODD : GOLD_EVEN;
    assign gprod = GP_W'(r_ke) * GP_W'(gold);
    assign sprod = (P1_W+2)'(r_q) * (P1_W+2)'(i_echo_train_length);
    assign eq    = r_order_q == r_val;

    // Offset memory: written by the generator and the duplicate repair,
    // read by the duplicate scan and by queries.
    assign order_we    = ((r_state == S_GWAIT) && i_div_rsp.done) || (r_state == S_RWR);
    assign order_waddr = (r_state == S_RWR) ? r_dup_q : r_k;
    assign order_wdata = (r_state == S_RWR) ? r_miss_q : AW'(i_div_rsp.remainder);
    assign order_raddr = (r_state == S_QMUL) ? AW'(r_echo) : r_m;

    assign dup_we  = (r_state == S_SCMP) && eq && r_seen;
    assign miss_we = (r_state == S_SCMP) && (r_m == etl_m1) && !(r_seen || eq);

    always_ff @(posedge i_clk) begin
        if (order_we) begin
            mem_order[order_waddr] <= order_wdata;
        end
        r_order_q <= mem_order[order_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (dup_we) begin
            mem_dup[r_ndup] <= r_m;
        end
        r_dup_q <= mem_dup[r_k];
    end

    always_ff @(posedge i_clk) begin
        if (miss_we) begin
            mem_miss[r_nmis] <= r_val;
        end
        r_miss_q <= mem_miss[r_k];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ready     <= 1'b0;
            r_out_valid <= 1'b0;
            r_div_start <= 1'b0;
            r_stride    <= '0;
        end else begin
            r_div_start <= 1'b0;
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_take) begin
                        if (i_in_data.command == CMD_BUILD) begin
                            if (cfg_ok) begin
                                r_k     <= '0;
                                r_state <= S_GMUL1;
                            end else begin
                                r_ready           <= 1'b0;
                                r_out_valid       <= 1'b1;
                                r_out.view_number <= '0;
                                r_out.status      <= STATUS_RANGE;
                            end
                        end else if (!r_ready) begin
                            r_out_valid       <= 1'b1;
                            r_out.view_number <= '0;
                            r_out.status      <= STATUS_NOT_BUILT;
                        end else if (echo_bad || slot_bad) begin
                            r_out_valid       <= 1'b1;
                            r_out.view_number <= '0;
                            r_out.status      <= STATUS_RANGE;
                        end else begin
                            r_echo  <= i_in_data.echo_index;
                            r_slot  <= i_in_data.slot_index;
                            r_state <= S_QMUL;
                        end
                    end
                end
                S_GMUL1: begin
                    r_ke    <= KE_W'(KE_W'(r_k) * KE_W'(i_echo_train_length));
                    r_state <= S_GMUL2;
                end
                S_GMUL2: begin
                    // Integer part of k * etl * G, then reduced modulo etl.
                    r_dividend  <= DIV_W'(gprod[GP_W-1:GOLD_W]);
                    r_divisor   <= DVS_W'(i_echo_train_length);
                    r_div_start <= 1'b1;
                    r_state     <= S_GWAIT;
                end
                S_GWAIT: begin
                    if (i_div_rsp.done) begin
                        if (r_k == etl_m1) begin
                            r_val   <= '0;
                            r_m     <= '0;
                            r_seen  <= 1'b0;
                            r_ndup  <= '0;
                            r_nmis  <= '0;
                            r_state <= S_SRD;
                        end else begin
                            r_k     <= r_k + AW'(1);
                            r_state <= S_GMUL1;
                        end
                    end
                end
                S_SRD: begin
                    r_state <= S_SCMP;
                end
                S_SCMP: begin
                    // Every value is searched over all positions; repeats after
                    // the first hit are duplicates, values never hit are missing.
                    if (eq && r_seen) begin
                        r_ndup <= r_ndup + AW'(1);
                    end
                    if (eq) begin
                        r_seen <= 1'b1;
                    end
                    if (r_m == etl_m1) begin
                        if (!(r_seen || eq)) begin
                            r_nmis <= r_nmis + AW'(1);
                        end
                        r_m    <= '0;
                        r_seen <= 1'b0;
                        if (r_val == etl_m1) begin
                            r_k     <= '0;
                            r_state <= S_RRD;
                        end else begin
                            r_val   <= r_val + AW'(1);
                            r_state <= S_SRD;
                        end
                    end else begin
                        r_m     <= r_m + AW'(1);
                        r_state <= S_SRD;
                    end
                end
                S_RRD: begin
                    // There are as many missing values as duplicates.
                    if (r_k == r_ndup) begin
                        r_state <= S_NT;
                    end else begin
                        r_state <= S_RWR;
                    end
                end
                S_RWR: begin
                    r_k     <= r_k + AW'(1);
                    r_state <= S_RRD;
                end
                S_NT: begin
                    r_dividend  <= DIV_W'(VC_W'(i_view_count) + VC_W'(i_echo_train_length)
                                          - VC_W'(1));
                    r_divisor   <= DVS_W'(i_echo_train_length);
                    r_div_start <= 1'b1;
                    r_state     <= S_NTWAIT;
                end
                S_NTWAIT: begin
                    if (i_div_rsp.done) begin
                        r_ntrains <= NT_W'(i_div_rsp.quotient);
                        r_state   <= S_QT;
                    end
                end
                S_QT: begin
                    // Round half up: (2 * trains + etl) / (2 * etl).
                    r_dividend  <= DIV_W'({r_ntrains, 1'b0}) + DIV_W'(i_echo_train_length);
                    r_divisor   <= DVS_W'({i_echo_train_length, 1'b0});
                    r_div_start <= 1'b1;
                    r_state     <= S_QTWAIT;
                end
                S_QTWAIT: begin
                    if (i_div_rsp.done) begin
                        r_q     <= NT_W'(i_div_rsp.quotient);
                        r_state <= S_STRIDE;
                    end
                end
                S_STRIDE: begin
                    if (r_q == '0) begin
                        r_stride <= STRIDE_W'(i_echo_train_length);
                    end else begin
                        r_stride <= STRIDE_W'(sprod);
                    end
                    r_ready           <= 1'b1;
                    r_out_valid       <= 1'b1;
                    r_out.view_number <= '0;
                    r_out.status      <= STATUS_OK;
                    r_state           <= S_IDLE;
                end
                S_QMUL: begin
                    r_p1    <= P1_W'(P1_W'(r_echo) * P1_W'(r_stride));
                    r_p2    <= P2_W'(P2_W'(r_slot) * P2_W'(i_echo_train_length));
                    r_state <= S_QSUM;
                end
                S_QSUM: begin
                    r_dividend  <= DIV_W'(r_p1) + DIV_W'(r_p2) + DIV_W'(r_order_q);
                    r_divisor   <= DVS_W'(i_view_count);
                    r_div_start <= 1'b1;
                    r_state     <= S_QWAIT;
                end
                S_QWAIT: begin
                    if (i_div_rsp.done) begin
                        r_out_valid       <= 1'b1;
                        r_out.view_number <= VIEW_W'(i_div_rsp.remainder);
                        r_out.status      <= STATUS_OK;
                        r_state           <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            // Any register write invalidates the table.
            if (i_cfg_wr) begin
                r_ready <= 1'b0;
            end
        end
    end

    assign o_in_stall  = in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign o_div_req.start    = r_div_start;
    assign o_div_req.dividend = r_dividend;
    assign o_div_req.divisor  = r_divisor;

endmodule
